FILE: rtl/core/iecfc_pkg.sv
package iecfc_pkg;

  // Search sequencer for the sample counter of a sampled-values frame.
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_LEN  = 3'd1,
    PH_TAG  = 3'd2,
    PH_HI   = 3'd3,
    PH_LO   = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  typedef logic [2:0] frame_class_t;
  typedef logic [1:0] sv_variant_t;
  typedef logic [1:0] count_status_t;

  localparam frame_class_t CLS_UNKNOWN = 3'd0;
  localparam frame_class_t CLS_TCP     = 3'd1;
  localparam frame_class_t CLS_UDP     = 3'd2;
  localparam frame_class_t CLS_ARP     = 3'd3;
  localparam frame_class_t CLS_GOOSE   = 3'd4;
  localparam frame_class_t CLS_SV      = 3'd5;

  localparam sv_variant_t VAR_NONE = 2'd0;
  localparam sv_variant_t VAR_92   = 2'd1;
  localparam sv_variant_t VAR_91   = 2'd2;

  localparam count_status_t ST_NA       = 2'd0;
  localparam count_status_t ST_FOUND    = 2'd1;
  localparam count_status_t ST_HOP_LIM  = 2'd2;
  localparam count_status_t ST_SHORT    = 2'd3;

  localparam logic [15:0] ET_VLAN  = 16'h8100;
  localparam logic [15:0] ET_GOOSE = 16'h88B8;
  localparam logic [15:0] ET_SV    = 16'h88BA;
  localparam logic [15:0] ET_IPV4  = 16'h0800;
  localparam logic [15:0] ET_ARP   = 16'h0806;

  localparam logic [7:0] PROTO_TCP     = 8'h06;
  localparam logic [7:0] PROTO_UDP     = 8'h11;
  localparam logic [7:0] TAG_SMPCNT    = 8'h82;
  localparam logic [7:0] SHORT_LEN_MAX = 8'h3C;
  localparam logic [7:0] LONG_LEN_BASE = 8'h80;
  localparam logic [7:0] PDU_91        = 8'h80;
  localparam logic [7:0] PDU_92        = 8'h60;

  // Frame byte positions (tagged layout; untagged sampled values sit 4 lower).
  localparam int unsigned POS_OUTER_HI   = 12;
  localparam int unsigned POS_OUTER_LO   = 13;
  localparam int unsigned POS_INNER_HI   = 16;
  localparam int unsigned POS_INNER_LO   = 17;
  localparam int unsigned POS_PDU_UNTAG  = 22;
  localparam int unsigned POS_IP_PROTO   = 23;
  localparam int unsigned POS_PDU_TAGGED = 26;
  localparam int unsigned OFS_91_COUNT   = 46;

endpackage

FILE: rtl/core/iec61850_frame_classifier_top.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    in_data_byte[7:0], in_last_byte
// out_      output     out_valid/out_ready  out_frame_class[2:0], out_vlan_tagged,
//                                           out_sv_variant[1:0], out_sample_count[15:0],
//                                           out_count_status[1:0]
// cfg_      input      cfg_wr_en            cfg_wr_data[7:0] (frame start offset)
//
// One byte is transferred per cycle; each byte is parsed in the cycle it is accepted.
// The result of a frame is loaded into the output register in the cycle after its last byte.
// Synchronous active-low reset clears the offset, the frame state and the output valid.
// Input stalls only while a result waits in the output register and out_ready is low.
module iec61850_frame_classifier_top #(
  parameter int unsigned MAX_TAG_HOPS    = 100,
  parameter int unsigned MAX_FRAME_BYTES = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_frame_class,
  output logic        out_vlan_tagged,
  output logic [1:0]  out_sv_variant,
  output logic [15:0] out_sample_count,
  output logic [1:0]  out_count_status,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  // Position counters hold values up to MAX_FRAME_BYTES, which also marks saturation.
  localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned CMP_W = (POS_W > 8) ? POS_W : 8;
  // A jump target can exceed the frame limit by at most 128 before saturating.
  localparam int unsigned TGT_W = POS_W + 2;
  localparam int unsigned HOP_W = $clog2(MAX_TAG_HOPS + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

  logic [7:0]       cfg_offset_r;

  logic [POS_W-1:0] byte_pos_r,  byte_pos_nxt;
  logic [15:0]      outer_r,     outer_nxt;
  logic [15:0]      inner_r,     inner_nxt;
  logic [7:0]       proto_r,     proto_nxt;
  logic [1:0]       variant_r,   variant_nxt;
  logic [POS_W-1:0] target_r,    target_nxt;
  logic [HOP_W-1:0] hop_r,       hop_nxt;
  iecfc_pkg::phase_t phase_r,    phase_nxt;
  logic [15:0]      count_r,     count_nxt;
  logic [1:0]       status_r,    status_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       out_class_r, out_class_nxt;
  logic             out_vlan_r,  out_vlan_nxt;
  logic [1:0]       out_var_r,   out_var_nxt;
  logic [15:0]      out_count_r, out_count_nxt;
  logic [1:0]       out_stat_r,  out_stat_nxt;

  logic             in_fire;

  // The output register is the only buffer: a new byte may enter whenever the slot
  // is empty or is being emptied in this cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  function automatic logic [POS_W-1:0] sat_pos(input logic [TGT_W-1:0] v);
    if (v > TGT_W'(MAX_FRAME_BYTES)) begin
      sat_pos = POS_MAX;
    end else begin
      sat_pos = v[POS_W-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_offset_r <= 8'd0;
    end else if (cfg_wr_en) begin
      cfg_offset_r <= cfg_wr_data;
    end
  end

  // Frame state and the sequencer register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= '0;
      outer_r    <= '0;
      inner_r    <= '0;
      proto_r    <= '0;
      variant_r  <= '0;
      target_r   <= '0;
      hop_r      <= '0;
      phase_r    <= iecfc_pkg::PH_IDLE;
      count_r    <= '0;
      status_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      byte_pos_r <= byte_pos_nxt;
      outer_r    <= outer_nxt;
      inner_r    <= inner_nxt;
      proto_r    <= proto_nxt;
      variant_r  <= variant_nxt;
      target_r   <= target_nxt;
      hop_r      <= hop_nxt;
      phase_r    <= phase_nxt;
      count_r    <= count_nxt;
      status_r   <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    out_class_r <= out_class_nxt;
    out_vlan_r  <= out_vlan_nxt;
    out_var_r   <= out_var_nxt;
    out_count_r <= out_count_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  always_comb begin
    logic [POS_W-1:0] p;
    logic [TGT_W-1:0] p_ext;
    logic [7:0]       skip;
    logic [HOP_W-1:0] hop_inc;
    logic             at_pdu;
    logic             is_sv;
    logic [2:0]       cls;
    logic [1:0]       stat;

    byte_pos_nxt  = byte_pos_r;
    outer_nxt     = outer_r;
    inner_nxt     = inner_r;
    proto_nxt     = proto_r;
    variant_nxt   = variant_r;
    target_nxt    = target_r;
    hop_nxt       = hop_r;
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    status_nxt    = status_r;

    p       = POS_W'(CMP_W'(byte_pos_r) - CMP_W'(cfg_offset_r));
    p_ext   = TGT_W'(p);
    hop_inc = hop_r + HOP_W'(1);
    at_pdu  = ((outer_r == iecfc_pkg::ET_SV) && (p == POS_W'(iecfc_pkg::POS_PDU_UNTAG))) ||
              ((outer_r == iecfc_pkg::ET_VLAN) && (inner_r == iecfc_pkg::ET_SV) &&
               (p == POS_W'(iecfc_pkg::POS_PDU_TAGGED)));

    // BER length: long form skips the length octets, short form (1..0x3C) skips the content.
    if (in_data_byte > iecfc_pkg::LONG_LEN_BASE) begin
      skip = in_data_byte - iecfc_pkg::LONG_LEN_BASE + 8'd1;
    end else if ((in_data_byte >= 8'd1) && (in_data_byte <= iecfc_pkg::SHORT_LEN_MAX)) begin
      skip = in_data_byte + 8'd1;
    end else begin
      skip = 8'd1;
    end

    if (in_fire && (byte_pos_r < POS_MAX)) begin
      byte_pos_nxt = byte_pos_r + POS_W'(1);
      if (CMP_W'(byte_pos_r) >= CMP_W'(cfg_offset_r)) begin
        if ((p == POS_W'(iecfc_pkg::POS_OUTER_HI)) || (p == POS_W'(iecfc_pkg::POS_OUTER_LO))) begin
          outer_nxt = {outer_r[7:0], in_data_byte};
        end
        if (((p == POS_W'(iecfc_pkg::POS_INNER_HI)) || (p == POS_W'(iecfc_pkg::POS_INNER_LO))) &&
            (outer_r == iecfc_pkg::ET_VLAN)) begin
          inner_nxt = {inner_r[7:0], in_data_byte};
        end
        if ((p == POS_W'(iecfc_pkg::POS_IP_PROTO)) && (outer_r == iecfc_pkg::ET_IPV4)) begin
          proto_nxt = in_data_byte;
        end

        if (phase_r == iecfc_pkg::PH_IDLE) begin
          if (at_pdu) begin
            if (in_data_byte == iecfc_pkg::PDU_92) begin
              variant_nxt = iecfc_pkg::VAR_92;
              hop_nxt     = '0;
              target_nxt  = sat_pos(p_ext + TGT_W'(1));
              phase_nxt   = iecfc_pkg::PH_LEN;
            end else if (in_data_byte == iecfc_pkg::PDU_91) begin
              variant_nxt = iecfc_pkg::VAR_91;
              target_nxt  = sat_pos(p_ext + TGT_W'(iecfc_pkg::OFS_91_COUNT));
              phase_nxt   = iecfc_pkg::PH_HI;
            end else begin
              variant_nxt = iecfc_pkg::VAR_NONE;
              phase_nxt   = iecfc_pkg::PH_DONE;
            end
          end
        end else if (p == target_r) begin
          case (phase_r)
            iecfc_pkg::PH_LEN: begin
              target_nxt = sat_pos(p_ext + TGT_W'(skip));
              phase_nxt  = iecfc_pkg::PH_TAG;
            end
            iecfc_pkg::PH_TAG: begin
              hop_nxt = hop_inc;
              if (in_data_byte == iecfc_pkg::TAG_SMPCNT) begin
                target_nxt = sat_pos(p_ext + TGT_W'(2));
                phase_nxt  = iecfc_pkg::PH_HI;
              end else if (hop_inc >= HOP_W'(MAX_TAG_HOPS)) begin
                status_nxt = iecfc_pkg::ST_HOP_LIM;
                phase_nxt  = iecfc_pkg::PH_DONE;
              end else begin
                target_nxt = sat_pos(p_ext + TGT_W'(1));
                phase_nxt  = iecfc_pkg::PH_LEN;
              end
            end
            iecfc_pkg::PH_HI: begin
              count_nxt  = {in_data_byte, 8'h00};
              target_nxt = sat_pos(p_ext + TGT_W'(1));
              phase_nxt  = iecfc_pkg::PH_LO;
            end
            iecfc_pkg::PH_LO: begin
              count_nxt  = {count_r[15:8], in_data_byte};
              status_nxt = iecfc_pkg::ST_FOUND;
              phase_nxt  = iecfc_pkg::PH_DONE;
            end
            default: begin
            end
          endcase
        end
      end
    end

    // Classification looks at the state including the byte of this cycle.
    is_sv = (outer_nxt == iecfc_pkg::ET_SV) ||
            ((outer_nxt == iecfc_pkg::ET_VLAN) && (inner_nxt == iecfc_pkg::ET_SV));
    cls = iecfc_pkg::CLS_UNKNOWN;
    if (outer_nxt == iecfc_pkg::ET_IPV4) begin
      if (proto_nxt == iecfc_pkg::PROTO_TCP) begin
        cls = iecfc_pkg::CLS_TCP;
      end else if (proto_nxt == iecfc_pkg::PROTO_UDP) begin
        cls = iecfc_pkg::CLS_UDP;
      end
    end else if (outer_nxt == iecfc_pkg::ET_ARP) begin
      cls = iecfc_pkg::CLS_ARP;
    end else if ((outer_nxt == iecfc_pkg::ET_GOOSE) ||
                 ((outer_nxt == iecfc_pkg::ET_VLAN) && (inner_nxt == iecfc_pkg::ET_GOOSE))) begin
      cls = iecfc_pkg::CLS_GOOSE;
    end else if (is_sv) begin
      cls = iecfc_pkg::CLS_SV;
    end

    // A variant without a final status means the frame ended before the counter.
    stat = iecfc_pkg::ST_NA;
    if ((cls == iecfc_pkg::CLS_SV) && (variant_nxt != iecfc_pkg::VAR_NONE)) begin
      stat = (status_nxt != iecfc_pkg::ST_NA) ? status_nxt : iecfc_pkg::ST_SHORT;
    end

    out_class_nxt = out_class_r;
    out_vlan_nxt  = out_vlan_r;
    out_var_nxt   = out_var_r;
    out_count_nxt = out_count_r;
    out_stat_nxt  = out_stat_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (in_fire && in_last_byte) begin
      out_valid_nxt = 1'b1;
      out_class_nxt = cls;
      out_vlan_nxt  = (outer_nxt == iecfc_pkg::ET_VLAN);
      out_var_nxt   = (cls == iecfc_pkg::CLS_SV) ? variant_nxt : iecfc_pkg::VAR_NONE;
      out_count_nxt = (stat == iecfc_pkg::ST_FOUND) ? count_nxt : 16'd0;
      out_stat_nxt  = stat;

      // The frame is complete: start the next one from a clean state.
      byte_pos_nxt = '0;
      outer_nxt    = '0;
      inner_nxt    = '0;
      proto_nxt    = '0;
      variant_nxt  = '0;
      target_nxt   = '0;
      hop_nxt      = '0;
      phase_nxt    = iecfc_pkg::PH_IDLE;
      count_nxt    = '0;
      status_nxt   = '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_class  = out_class_r;
  assign out_vlan_tagged  = out_vlan_r;
  assign out_sv_variant   = out_var_r;
  assign out_sample_count = out_count_r;
  assign out_count_status = out_stat_r;

  // A count status or a variant is only ever reported for a sampled-values frame.
  a_status_only_sv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((out_stat_r != iecfc_pkg::ST_NA) || (out_var_r != iecfc_pkg::VAR_NONE)))
      |-> (out_class_r == iecfc_pkg::CLS_SV))
    else $error("count status or variant reported for a non-SV frame");

  // The sample count is zero unless it was found.
  a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_stat_r != iecfc_pkg::ST_FOUND)) |-> (out_count_r == 16'd0))
    else $error("sample count set without found status");

  // The hop counter is left at zero whenever the search is idle.
  a_hop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == iecfc_pkg::PH_IDLE) |-> (hop_r == '0))
    else $error("hop counter non-zero while search idle");

  // Transfer of the last byte clears the frame state and loads a result.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_last_byte) |=>
      (out_valid_r && (byte_pos_r == '0) && (phase_r == iecfc_pkg::PH_IDLE)))
    else $error("frame state not cleared after last byte");

endmodule

FILE: dv/iec61850_frame_classifier_top_test.sv
module iec61850_frame_classifier_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // The block is built with its default sizes, and the predictor uses the same values.
  localparam int unsigned MAX_TAG_HOPS    = 100;
  localparam int unsigned MAX_FRAME_BYTES = 2048;

  // These numbers set when the random traffic stops.
  // The watchdog must stay well above the deliberate receiver hold-off.
  localparam int unsigned RANDOM_BYTES       = 300;
  localparam int unsigned RANDOM_FRAMES_MIN  = 6;
  localparam int unsigned HOLD_OFF_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT     = 4000;

  // These are the frame shapes that the stimulus generator can build.
  typedef enum int {
    FR_TCP, FR_UDP, FR_IP_OTHER, FR_ARP, FR_GOOSE,
    FR_SV91, FR_SV92, FR_SV_OTHER, FR_NOISE
  } frame_kind_t;

  // This holds one frame summary as it leaves the block on the result channel.
  typedef struct packed {
    iecfc_pkg::frame_class_t  cls;
    logic                     vlan;
    iecfc_pkg::sv_variant_t   variant;
    logic [15:0]              smp_cnt;
    iecfc_pkg::count_status_t status;
  } frame_summary_t;

  // The scoreboard keeps its own copy of the parser state and predicts the summary
  // of each frame when the transfer that carries the last byte of that frame is seen.
  // The expected summaries wait in order until the result channel returns them.
  class frame_scoreboard;
    logic [7:0]               start_offset;
    int unsigned              stream_pos;
    int unsigned              target_pos;
    logic [15:0]              outer_et;
    logic [15:0]              inner_et;
    logic [15:0]              cnt;
    logic [7:0]               ip_proto;
    iecfc_pkg::sv_variant_t   variant;
    logic [6:0]               hops;
    iecfc_pkg::phase_t        phase;
    iecfc_pkg::count_status_t status;
    frame_summary_t           pending[$];
    int                       errors;

    function new();
      start_offset = '0;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      stream_pos = 0;
      target_pos = 0;
      outer_et = '0;
      inner_et = '0;
      cnt = '0;
      ip_proto = '0;
      variant = iecfc_pkg::VAR_NONE;
      hops = '0;
      phase = iecfc_pkg::PH_IDLE;
      status = iecfc_pkg::ST_NA;
    endfunction

    // A target position beyond the parsed window saturates, so it is never reached.
    function void aim(int unsigned pos);
      target_pos = (pos > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : pos;
    endfunction

    function void parse(int unsigned p, logic [7:0] b);
      bit at_pdu;
      if (p == iecfc_pkg::POS_OUTER_HI || p == iecfc_pkg::POS_OUTER_LO)
        outer_et = {outer_et[7:0], b};
      if ((p == iecfc_pkg::POS_INNER_HI || p == iecfc_pkg::POS_INNER_LO) &&
          outer_et == iecfc_pkg::ET_VLAN)
        inner_et = {inner_et[7:0], b};
      if (p == iecfc_pkg::POS_IP_PROTO && outer_et == iecfc_pkg::ET_IPV4) ip_proto = b;
      if (phase == iecfc_pkg::PH_IDLE) begin
        at_pdu = (outer_et == iecfc_pkg::ET_SV && p == iecfc_pkg::POS_PDU_UNTAG) ||
                 (outer_et == iecfc_pkg::ET_VLAN && inner_et == iecfc_pkg::ET_SV &&
                  p == iecfc_pkg::POS_PDU_TAGGED);
        if (at_pdu) begin
          if (b == iecfc_pkg::PDU_92) begin
            variant = iecfc_pkg::VAR_92;
            hops = '0;
            aim(p + 1);
            phase = iecfc_pkg::PH_LEN;
          end else if (b == iecfc_pkg::PDU_91) begin
            variant = iecfc_pkg::VAR_91;
            aim(p + iecfc_pkg::OFS_91_COUNT);
            phase = iecfc_pkg::PH_HI;
          end else begin
            variant = iecfc_pkg::VAR_NONE;
            phase = iecfc_pkg::PH_DONE;
          end
        end
      end else if (p == target_pos) begin
        case (phase)
          iecfc_pkg::PH_LEN: begin
            if (b > iecfc_pkg::LONG_LEN_BASE) aim(p + b - iecfc_pkg::LONG_LEN_BASE + 1);
            else if (b >= 1 && b <= iecfc_pkg::SHORT_LEN_MAX) aim(p + b + 1);
            else aim(p + 1);
            phase = iecfc_pkg::PH_TAG;
          end
          iecfc_pkg::PH_TAG: begin
            hops = hops + 7'd1;
            if (b == iecfc_pkg::TAG_SMPCNT) begin
              aim(p + 2);
              phase = iecfc_pkg::PH_HI;
            end else if (hops >= MAX_TAG_HOPS) begin
              status = iecfc_pkg::ST_HOP_LIM;
              phase = iecfc_pkg::PH_DONE;
            end else begin
              aim(p + 1);
              phase = iecfc_pkg::PH_LEN;
            end
          end
          iecfc_pkg::PH_HI: begin
            cnt = {b, 8'h00};
            aim(p + 1);
            phase = iecfc_pkg::PH_LO;
          end
          iecfc_pkg::PH_LO: begin
            cnt = {cnt[15:8], b};
            status = iecfc_pkg::ST_FOUND;
            phase = iecfc_pkg::PH_DONE;
          end
          default: ;
        endcase
      end
    endfunction

    function void note_byte(logic [7:0] d, logic is_last);
      frame_summary_t r;
      if (stream_pos < MAX_FRAME_BYTES) begin
        if (stream_pos >= start_offset) parse(stream_pos - start_offset, d);
        stream_pos++;
      end
      if (is_last) begin
        r = '0;
        if (outer_et == iecfc_pkg::ET_IPV4) begin
          if (ip_proto == iecfc_pkg::PROTO_TCP) r.cls = iecfc_pkg::CLS_TCP;
          else if (ip_proto == iecfc_pkg::PROTO_UDP) r.cls = iecfc_pkg::CLS_UDP;
        end else if (outer_et == iecfc_pkg::ET_ARP) begin
          r.cls = iecfc_pkg::CLS_ARP;
        end else if (outer_et == iecfc_pkg::ET_GOOSE ||
                     (outer_et == iecfc_pkg::ET_VLAN && inner_et == iecfc_pkg::ET_GOOSE)) begin
          r.cls = iecfc_pkg::CLS_GOOSE;
        end else if (outer_et == iecfc_pkg::ET_SV ||
                     (outer_et == iecfc_pkg::ET_VLAN && inner_et == iecfc_pkg::ET_SV)) begin
          r.cls = iecfc_pkg::CLS_SV;
        end
        r.vlan = (outer_et == iecfc_pkg::ET_VLAN);
        if (r.cls == iecfc_pkg::CLS_SV) begin
          r.variant = variant;
          if (variant != iecfc_pkg::VAR_NONE) begin
            r.status = (status != iecfc_pkg::ST_NA) ? status : iecfc_pkg::ST_SHORT;
            if (r.status == iecfc_pkg::ST_FOUND) r.smp_cnt = cnt;
          end
        end
        pending.push_back(r);
        clear_frame();
      end
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(frame_summary_t got);
      frame_summary_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected frame summary, class %0d status %0d", $time, got.cls,
                 got.status);
        return;
      end
      want = pending.pop_front();
      check_field("frame_class", 16'(want.cls), 16'(got.cls));
      check_field("vlan_tagged", 16'(want.vlan), 16'(got.vlan));
      check_field("sv_variant", 16'(want.variant), 16'(got.variant));
      check_field("sample_count", want.smp_cnt, got.smp_cnt);
      check_field("count_status", 16'(want.status), 16'(got.status));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_frame_class;
  logic        out_vlan_tagged;
  logic [1:0]  out_sv_variant;
  logic [15:0] out_sample_count;
  logic [1:0]  out_count_status;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  frame_scoreboard sb = new();
  frame_summary_t  seen_result;
  logic [7:0]      stream_q[$];

  // Idle percentages of each side; only the stimulus process writes them.
  int unsigned sender_gap_pct = 0;
  int unsigned receiver_gap_pct = 0;
  // The stimulus process raises hold_requests, and the receiver serves each request
  // by counting out its own hold-off.
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  iec61850_frame_classifier_top #(
    .MAX_TAG_HOPS    (MAX_TAG_HOPS),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_class  (out_frame_class),
    .out_vlan_tagged  (out_vlan_tagged),
    .out_sv_variant   (out_sv_variant),
    .out_sample_count (out_sample_count),
    .out_count_status (out_count_status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side. Each process reads the handshake right after the rising edge, before
  // any nonblocking update lands, so it sees the values that were present at the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_result = {out_frame_class, out_vlan_tagged, out_sv_variant, out_sample_count,
                     out_count_status};
      sb.check_result(seen_result);
    end
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_gap_pct);
    end
  end

  // The watchdog counts cycles in which no transfer happens on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void put(logic [7:0] v);
    stream_q.push_back(v);
  endfunction

  function automatic void put_rand(int unsigned n);
    for (int i = 0; i < n; i++) stream_q.push_back(8'($urandom_range(255)));
  endfunction

  // This writes one BER length field for the sampled-values walk. Mode 0 gives a
  // random mix that includes the short-form ceiling and the 0x80 boundary. Mode 1
  // gives a zero length, which steps one byte. Mode 2 gives the longest long-form skip.
  function automatic void put_length(int unsigned mode);
    int unsigned r;
    int unsigned n;
    r = $urandom_range(99);
    if (mode == 1) begin
      put(8'h00);
    end else if (mode == 2 || r >= 97) begin
      n = (mode == 2) ? 127 : $urandom_range(4, 127);
      put(8'(iecfc_pkg::LONG_LEN_BASE + n));
      put_rand(n);
    end else if (r < 60) begin
      n = $urandom_range(1, 6);
      put(8'(n));
      put_rand(n);
    end else if (r < 68) begin
      n = $urandom_range(1) ? iecfc_pkg::SHORT_LEN_MAX :
                              $urandom_range(7, iecfc_pkg::SHORT_LEN_MAX);
      put(8'(n));
      put_rand(n);
    end else if (r < 88) begin
      n = $urandom_range(1, 3);
      put(8'(iecfc_pkg::LONG_LEN_BASE + n));
      put_rand(n);
    end else begin
      put($urandom_range(1) ? 8'h00 :
          8'($urandom_range(iecfc_pkg::SHORT_LEN_MAX + 1, iecfc_pkg::LONG_LEN_BASE)));
    end
  endfunction

  // This builds the skipped prefix and then one frame in stream_q. For a 9-2 frame,
  // hops sets how many foreign tags come before the sample-count tag.
  function automatic void build_frame(frame_kind_t kind, bit vlan_on, int unsigned hops,
                                      int unsigned mode, bit with_count);
    logic [15:0] et;
    logic [7:0]  v;
    stream_q.delete();
    put_rand(32'(sb.start_offset));
    put_rand(12);
    if (vlan_on) begin
      put(iecfc_pkg::ET_VLAN[15:8]);
      put(iecfc_pkg::ET_VLAN[7:0]);
      put_rand(2);
    end
    case (kind)
      FR_TCP, FR_UDP, FR_IP_OTHER: et = iecfc_pkg::ET_IPV4;
      FR_ARP:                      et = iecfc_pkg::ET_ARP;
      FR_GOOSE:                    et = iecfc_pkg::ET_GOOSE;
      FR_NOISE:                    et = 16'($urandom_range(16'hFFFF));
      default:                     et = iecfc_pkg::ET_SV;
    endcase
    put(et[15:8]);
    put(et[7:0]);
    case (kind)
      FR_TCP, FR_UDP, FR_IP_OTHER: begin
        if (kind == FR_TCP) v = iecfc_pkg::PROTO_TCP;
        else if (kind == FR_UDP) v = iecfc_pkg::PROTO_UDP;
        else do v = 8'($urandom_range(255));
          while (v == iecfc_pkg::PROTO_TCP || v == iecfc_pkg::PROTO_UDP);
        put(8'h45);
        put_rand(8);
        put(v);
        put_rand(10 + $urandom_range(20));
      end
      FR_ARP: put_rand(28);
      FR_GOOSE: put_rand(8 + $urandom_range(30));
      FR_SV91: begin
        put_rand(8);
        put(iecfc_pkg::PDU_91);
        put_rand(47 + $urandom_range(4));
      end
      FR_SV92: begin
        put_rand(8);
        put(iecfc_pkg::PDU_92);
        for (int h = 0; h < hops; h++) begin
          put_length(mode);
          do v = 8'($urandom_range(255)); while (v == iecfc_pkg::TAG_SMPCNT);
          put(v);
        end
        if (with_count) begin
          put_length(mode);
          put(iecfc_pkg::TAG_SMPCNT);
          put_rand(3 + $urandom_range(4));
        end
      end
      FR_SV_OTHER: begin
        put_rand(8);
        do v = 8'($urandom_range(255));
          while (v == iecfc_pkg::PDU_91 || v == iecfc_pkg::PDU_92);
        put(v);
        put_rand($urandom_range(20));
      end
      default: put_rand($urandom_range(40));
    endcase
  endfunction

  // This offers one byte. Valid may drop for random idle cycles before the byte, but
  // once raised it holds with a steady payload until the transfer takes place.
  task automatic push_byte(logic [7:0] d, logic is_last);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(d, is_last);
  endtask

  task automatic send_bytes(int lo_idx, int hi_idx);
    for (int i = lo_idx; i <= hi_idx; i++) push_byte(stream_q[i], i == stream_q.size() - 1);
  endtask

  // This sends the built stream. When keep is non-zero, the stream is first cut down
  // to that many bytes.
  task automatic send_frame(int unsigned keep);
    if (keep != 0) while (stream_q.size() > keep) void'(stream_q.pop_back());
    send_bytes(0, stream_q.size() - 1);
  endtask

  task automatic run_frame(frame_kind_t kind, bit vlan_on, int unsigned hops,
                           int unsigned mode, bit with_count, int unsigned keep);
    build_frame(kind, vlan_on, hops, mode, with_count);
    send_frame(keep);
  endtask

  // The offset is written only when no summary is outstanding, and only after a short
  // pause with the sender idle.
  task automatic write_offset(logic [7:0] v);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.start_offset = v;
  endtask

  initial begin
    int unsigned rand_bytes;
    int unsigned rand_frames;
    int unsigned r;
    int unsigned keep;
    logic [7:0]  ofs;
    frame_kind_t kind;
    bit          vlan_on;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    sender_gap_pct = 22;
    receiver_gap_pct = 71;

    // The directed frames cover every class, both tag layouts, both sampled-values
    // variants and the walk corner cases.
    run_frame(FR_TCP, 0, 0, 0, 0, 0);
    run_frame(FR_UDP, 0, 0, 0, 0, 0);
    run_frame(FR_IP_OTHER, 0, 0, 0, 0, 0);
    // IPv4 behind a VLAN tag is not recognised.
    run_frame(FR_TCP, 1, 0, 0, 0, 0);
    run_frame(FR_ARP, 0, 0, 0, 0, 0);
    run_frame(FR_GOOSE, 0, 0, 0, 0, 0);
    run_frame(FR_GOOSE, 1, 0, 0, 0, 0);
    run_frame(FR_SV91, 0, 0, 0, 0, 0);
    run_frame(FR_SV91, 1, 0, 0, 0, 0);
    run_frame(FR_SV92, 0, 3, 0, 1, 0);
    run_frame(FR_SV92, 1, 0, 0, 1, 0);
    run_frame(FR_SV_OTHER, 1, 0, 0, 0, 0);
    // The walk finds the count on its last permitted tag, and then, with a foreign tag in
    // that place, runs out of hops.
    run_frame(FR_SV92, 0, MAX_TAG_HOPS - 1, 1, 1, 0);
    run_frame(FR_SV92, 1, MAX_TAG_HOPS, 1, 0, 0);
    // Each of these frames ends early: one before the 9-1 counter, one before the PDU
    // tag, one halfway through the EtherType, and one after a single byte.
    run_frame(FR_SV91, 0, 0, 0, 0, 53);
    run_frame(FR_SV92, 0, 0, 0, 1, 20);
    run_frame(FR_ARP, 0, 0, 0, 0, 13);
    run_frame(FR_ARP, 0, 0, 0, 0, 1);
    run_frame(FR_NOISE, 0, 0, 0, 0, 0);
    // With the largest offset, the second frame ends inside the skipped prefix.
    write_offset(8'hFF);
    run_frame(FR_SV91, 1, 0, 0, 0, 0);
    run_frame(FR_GOOSE, 0, 0, 0, 0, 100);
    // Here the offset changes partway through a frame while the sender is paused.
    write_offset(8'h00);
    build_frame(FR_SV91, 0, 0, 0, 0);
    send_bytes(0, 9);
    write_offset(8'h03);
    send_bytes(10, stream_q.size() - 1);
    write_offset(8'h00);

    // Random traffic is about half sampled-values frames, mixed with other classes,
    // truncated frames and noise. The idle pattern changes by thirds of the
    // byte budget.
    rand_bytes = 0;
    rand_frames = 0;
    while (rand_bytes < RANDOM_BYTES || rand_frames < RANDOM_FRAMES_MIN) begin
      if (rand_frames % 6 == 0) begin
        r = $urandom_range(99);
        if (r < 4) ofs = 8'hFF;
        else if (r < 20) ofs = 8'h00;
        else ofs = 8'($urandom_range(1, 16));
        write_offset(ofs);
      end
      if (rand_bytes < RANDOM_BYTES / 3) begin
        sender_gap_pct = 22;
        receiver_gap_pct = 71;
      end else if (rand_bytes < 2 * RANDOM_BYTES / 3) begin
        sender_gap_pct = 71;
        receiver_gap_pct = 22;
      end else begin
        // On entry to the phase without idling, the receiver holds off for a long
        // stretch, so the block backs up and stalls its input.
        if (sender_gap_pct != 0) hold_requests++;
        sender_gap_pct = 0;
        receiver_gap_pct = 0;
      end
      r = $urandom_range(99);
      if (r < 30) kind = FR_SV92;
      else if (r < 45) kind = FR_SV91;
      else if (r < 50) kind = FR_SV_OTHER;
      else if (r < 60) kind = FR_TCP;
      else if (r < 70) kind = FR_UDP;
      else if (r < 75) kind = FR_IP_OTHER;
      else if (r < 83) kind = FR_ARP;
      else if (r < 93) kind = FR_GOOSE;
      else kind = FR_NOISE;
      if (kind == FR_TCP || kind == FR_UDP || kind == FR_IP_OTHER || kind == FR_ARP)
        vlan_on = ($urandom_range(9) == 0);
      else
        vlan_on = ($urandom_range(1) != 0);
      r = $urandom_range(99);
      build_frame(kind, vlan_on, (r < 3) ? $urandom_range(90, 105) : $urandom_range(6), 0,
                  ($urandom_range(9) != 0));
      keep = ($urandom_range(99) < 15) ? $urandom_range(1, stream_q.size()) : 0;
      rand_bytes += (keep != 0) ? keep : stream_q.size();
      send_frame(keep);
      rand_frames++;
    end

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
